// ===== design/asbg_pkg.sv =====
package asbg_pkg;

    localparam int unsigned LEN_W   = 23;
    localparam int unsigned COUNT_W = 8;
    localparam int unsigned LEVEL_W = 15;
    localparam int unsigned GAIN_W  = 16;
    localparam int unsigned RANGE_W = 7;
    localparam int unsigned JIT_W   = 8;
    localparam int unsigned CLICK_W = 9;
    // threshold is spacing times (clicks + 1), clicks + 1 needs one bit more
    localparam int unsigned THR_W   = LEN_W + CLICK_W + 1;
    localparam int unsigned CMP_W   = THR_W + 1;
    localparam int unsigned JMUL_W  = 33;
    localparam int unsigned JIT_STEP = 441;
    localparam int unsigned GAIN_FRAC = 12;

    localparam int unsigned APB_DW = 32;
    localparam int unsigned APB_AW = 5;

    localparam logic [CLICK_W-1:0] CLICKS_MAX = '1;

    localparam logic [2:0] REG_ENABLE       = 3'd0;
    localparam logic [2:0] REG_BURST_LEN    = 3'd1;
    localparam logic [2:0] REG_SNAP_SPACING = 3'd2;
    localparam logic [2:0] REG_SNAP_COUNT   = 3'd3;
    localparam logic [2:0] REG_IDLE_LEN     = 3'd4;
    localparam logic [2:0] REG_SNAP_LEVEL   = 3'd5;
    localparam logic [2:0] REG_PASS_GAIN    = 3'd6;
    localparam logic [2:0] REG_JIT_RANGE    = 3'd7;

    localparam logic [LEN_W-1:0]   RST_BURST_LEN    = 23'd44100;
    localparam logic [LEN_W-1:0]   RST_SNAP_SPACING = 23'd22050;
    localparam logic [COUNT_W-1:0] RST_SNAP_COUNT   = 8'd1;
    localparam logic [LEN_W-1:0]   RST_IDLE_LEN     = 23'd4410;
    localparam logic [LEVEL_W-1:0] RST_SNAP_LEVEL   = 15'd16384;
    localparam logic [GAIN_W-1:0]  RST_PASS_GAIN    = 16'd4096;

    typedef struct packed {
        logic               enable;
        logic [LEN_W-1:0]   burst_samples;
        logic [LEN_W-1:0]   snap_spacing;
        logic [COUNT_W-1:0] snap_count;
        logic [LEN_W-1:0]   idle_samples;
        logic [LEVEL_W-1:0] snap_level;
        logic [GAIN_W-1:0]  pass_gain;
        logic [RANGE_W-1:0] jitter_range;
    } t_cfg;

endpackage

// ===== design/asbg_regs.sv =====
module asbg_regs (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [asbg_pkg::APB_AW-1:0]  paddr,
    input  logic [asbg_pkg::APB_DW-1:0]  pwdata,
    output logic [asbg_pkg::APB_DW-1:0]  prdata,
    output logic                         pready,
    output asbg_pkg::t_cfg               o_cfg
);
    import asbg_pkg::*;

    t_cfg       r_cfg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[APB_AW-1:2];
    assign o_cfg   = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable        <= 1'b0;
            r_cfg.burst_samples <= RST_BURST_LEN;
            r_cfg.snap_spacing  <= RST_SNAP_SPACING;
            r_cfg.snap_count    <= RST_SNAP_COUNT;
            r_cfg.idle_samples  <= RST_IDLE_LEN;
            r_cfg.snap_level    <= RST_SNAP_LEVEL;
            r_cfg.pass_gain     <= RST_PASS_GAIN;
            r_cfg.jitter_range  <= '0;
        end else if (wr_en) begin
            case (reg_idx)
                REG_ENABLE:       r_cfg.enable        <= pwdata[0];
                REG_BURST_LEN:    r_cfg.burst_samples <= pwdata[LEN_W-1:0];
                REG_SNAP_SPACING: r_cfg.snap_spacing  <= pwdata[LEN_W-1:0];
                REG_SNAP_COUNT:   r_cfg.snap_count    <= pwdata[COUNT_W-1:0];
                REG_IDLE_LEN:     r_cfg.idle_samples  <= pwdata[LEN_W-1:0];
                REG_SNAP_LEVEL:   r_cfg.snap_level    <= pwdata[LEVEL_W-1:0];
                REG_PASS_GAIN:    r_cfg.pass_gain     <= pwdata[GAIN_W-1:0];
                REG_JIT_RANGE:    r_cfg.jitter_range  <= pwdata[RANGE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        case (reg_idx)
            REG_ENABLE:       prdata = APB_DW'(r_cfg.enable);
            REG_BURST_LEN:    prdata = APB_DW'(r_cfg.burst_samples);
            REG_SNAP_SPACING: prdata = APB_DW'(r_cfg.snap_spacing);
            REG_SNAP_COUNT:   prdata = APB_DW'(r_cfg.snap_count);
            REG_IDLE_LEN:     prdata = APB_DW'(r_cfg.idle_samples);
            REG_SNAP_LEVEL:   prdata = APB_DW'(r_cfg.snap_level);
            REG_PASS_GAIN:    prdata = APB_DW'(r_cfg.pass_gain);
            REG_JIT_RANGE:    prdata = APB_DW'(r_cfg.jitter_range);
            default:          prdata = '0;
        endcase
    end

endmodule

// ===== design/asbg_core.sv =====
module asbg_core #(
    parameter int SAMPLE_WIDTH  = 16,
    parameter int COUNTER_WIDTH = 24
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  asbg_pkg::t_cfg                     i_cfg,
    input  logic                               i_step,
    input  logic signed [SAMPLE_WIDTH-1:0]     i_sample,
    input  logic signed [asbg_pkg::JIT_W-1:0]  i_jitter,
    output logic signed [SAMPLE_WIDTH-1:0]     o_sample
);
    import asbg_pkg::*;

    localparam int SW  = SAMPLE_WIDTH;
    localparam int CW  = COUNTER_WIDTH;
    localparam int PW  = SW + GAIN_W + 1;
    localparam int SCW = PW - GAIN_FRAC;
    localparam int YW  = (SCW > LEVEL_W + 1) ? SCW : LEVEL_W + 1;

    logic                 r_in_burst;
    logic [CW-1:0]        r_burst_cnt;
    logic [CW-1:0]        r_idle_cnt;
    logic [CLICK_W-1:0]   r_clicks;
    logic                 r_click_sign;

    logic                 n_in_burst;
    logic [CW-1:0]        n_burst_cnt;
    logic [CW-1:0]        n_idle_cnt;
    logic [CLICK_W-1:0]   n_clicks;
    logic                 n_click_sign;

    logic signed [JIT_W-1:0] rng_pos, rng_neg, jit_cl;
    logic [JMUL_W-1:0]    jit_mul;
    logic [CW-1:0]        jit_load;
    logic [CLICK_W:0]     clicks_p1;
    logic [THR_W-1:0]     thr;
    logic                 ge_thr, click_now;
    logic [CW-1:0]        burst_inc, idle_inc;
    logic                 burst_end, idle_end;
    logic signed [PW-1:0] prod;
    logic signed [SCW-1:0] scaled;
    logic signed [YW-1:0] lvl, y;
    logic                 sat_hi, sat_lo;

    function automatic logic signed [CMP_W-1:0] cnt_ext(input logic [CW-1:0] v);
        return CMP_W'($signed(v));
    endfunction

    // jitter clamp and load value, wrapped to counter width
    always_comb begin
        rng_pos = $signed({1'b0, i_cfg.jitter_range});
        rng_neg = -rng_pos;
        jit_cl  = i_jitter;
        if (i_jitter > rng_pos) jit_cl = rng_pos;
        if (i_jitter < rng_neg) jit_cl = rng_neg;
        jit_mul  = JMUL_W'(jit_cl) * JMUL_W'(JIT_STEP);
        jit_load = jit_mul[CW-1:0];
    end

    assign clicks_p1 = {1'b0, r_clicks} + 1'b1;
    assign thr       = THR_W'(i_cfg.snap_spacing) * THR_W'(clicks_p1);
    assign ge_thr    = cnt_ext(r_burst_cnt) >= $signed({1'b0, thr});
    assign click_now = (r_clicks < CLICK_W'(i_cfg.snap_count)) && ge_thr;

    // output datapath
    always_comb begin
        prod   = i_sample * $signed({1'b0, i_cfg.pass_gain});
        scaled = prod[PW-1:GAIN_FRAC];
        lvl    = YW'($signed({1'b0, i_cfg.snap_level}));
        if (!i_cfg.enable || !r_in_burst) begin
            y = YW'(i_sample);
        end else if (click_now) begin
            y = r_click_sign ? lvl : -lvl;
        end else begin
            y = YW'(scaled);
        end
        sat_hi = !y[YW-1] && (|y[YW-2:SW-1]);
        sat_lo = y[YW-1] && !(&y[YW-2:SW-1]);
        if (sat_hi) begin
            o_sample = {1'b0, {(SW-1){1'b1}}};
        end else if (sat_lo) begin
            o_sample = {1'b1, {(SW-1){1'b0}}};
        end else begin
            o_sample = y[SW-1:0];
        end
    end

    // phase and counter advance
    always_comb begin
        burst_inc = r_burst_cnt + 1'b1;
        idle_inc  = r_idle_cnt + 1'b1;
        burst_end = cnt_ext(burst_inc) >= $signed(CMP_W'(i_cfg.burst_samples));
        idle_end  = cnt_ext(idle_inc) >= $signed(CMP_W'(i_cfg.idle_samples));

        n_in_burst   = r_in_burst;
        n_burst_cnt  = r_burst_cnt;
        n_idle_cnt   = r_idle_cnt;
        n_clicks     = r_clicks;
        n_click_sign = r_click_sign;

        if (r_in_burst) begin
            n_burst_cnt = burst_inc;
            if (ge_thr && r_clicks != CLICKS_MAX) begin
                n_click_sign = !r_click_sign;
                n_clicks     = r_clicks + 1'b1;
            end
            if (burst_end) begin
                n_burst_cnt = '0;
                n_clicks    = '0;
                n_in_burst  = 1'b0;
                n_idle_cnt  = jit_load;
            end
        end else begin
            n_idle_cnt = idle_inc;
            if (idle_end) begin
                n_idle_cnt  = '0;
                n_in_burst  = 1'b1;
                n_clicks    = '0;
                n_burst_cnt = jit_load;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_burst   <= 1'b0;
            r_burst_cnt  <= '0;
            r_idle_cnt   <= '0;
            r_clicks     <= '0;
            r_click_sign <= 1'b0;
        end else if (i_step) begin
            r_in_burst   <= n_in_burst;
            r_burst_cnt  <= n_burst_cnt;
            r_idle_cnt   <= n_idle_cnt;
            r_clicks     <= n_clicks;
            r_click_sign <= n_click_sign;
        end
    end

endmodule

// ===== design/audio_snap_burst_generator.sv =====
// Pipeline: 2 register stages, input register then result register; input may stall.
// Throughput: 1 sample per cycle unless m_axis_tready holds the result; the phase counters
// and the click threshold multiply sit combinationally between the two registers.
// Reset (i_rst_n low, synchronous): idle phase, counters and click count zero,
// registers back to their defaults, both pipeline stages empty.
module audio_snap_burst_generator #(
    parameter int SAMPLE_WIDTH  = 16,
    parameter int COUNTER_WIDTH = 24
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // [SAMPLE_WIDTH-1:0] sample_in, [SAMPLE_WIDTH+7:SAMPLE_WIDTH] jitter, zero pad
    input  logic [((SAMPLE_WIDTH+asbg_pkg::JIT_W+7)/8)*8-1:0] s_axis_tdata,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // [SAMPLE_WIDTH-1:0] sample_out, zero pad
    output logic [((SAMPLE_WIDTH+7)/8)*8-1:0]     m_axis_tdata,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [asbg_pkg::APB_AW-1:0]           paddr,
    input  logic [asbg_pkg::APB_DW-1:0]           pwdata,
    output logic [asbg_pkg::APB_DW-1:0]           prdata,
    output logic                                  pready
);
    import asbg_pkg::*;

    localparam int SW    = SAMPLE_WIDTH;
    localparam int OUT_W = ((SW + 7) / 8) * 8;

    t_cfg                  cfg;
    logic                  r_in_valid;
    logic signed [SW-1:0]  r_in_sample;
    logic signed [JIT_W-1:0] r_in_jitter;
    logic                  r_out_valid;
    logic signed [SW-1:0]  r_out_sample;
    logic signed [SW-1:0]  core_sample;
    logic                  adv, in_xfer;

    asbg_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    asbg_core #(
        .SAMPLE_WIDTH  (SAMPLE_WIDTH),
        .COUNTER_WIDTH (COUNTER_WIDTH)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_step   (adv),
        .i_sample (r_in_sample),
        .i_jitter (r_in_jitter),
        .o_sample (core_sample)
    );

    // stage moves when the result slot is free or being drained
    assign adv           = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || adv;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = OUT_W'($unsigned(r_out_sample));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_in_valid <= 1'b1;
            end else if (adv) begin
                r_in_valid <= 1'b0;
            end
            if (adv) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_sample <= s_axis_tdata[SW-1:0];
            r_in_jitter <= s_axis_tdata[SW+JIT_W-1:SW];
        end
        if (adv) begin
            r_out_sample <= core_sample;
        end
    end

    a_bypass: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv && !cfg.enable |=> r_out_sample == $past(r_in_sample))
        else $error("bypass result differs from input sample");

    a_hold_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !adv |=> r_in_valid && $stable(r_in_sample) && $stable(r_in_jitter))
        else $error("stalled input stage lost its sample");

    a_adv_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        adv |=> r_out_valid)
        else $error("advanced sample produced no result");

endmodule
